@@ hdl/wpr_pkg.sv @@
`default_nettype none

package wpr_pkg;

  // Fixed widths of the graph, the degree bookkeeping and the rank format.
  localparam int NODE_W     = 6;
  localparam int MAX_NODES  = 64;
  localparam int CNT_W      = 7;
  localparam int RANK_W     = 32;
  localparam int FRAC_BITS  = 30;
  localparam int DAMP_W     = 16;
  localparam int ITER_W     = 16;
  localparam int DEG_W      = 7;
  localparam int OUTH_W     = 8;
  localparam int SIN_W      = 12;
  localparam int SOUT_W     = 13;
  localparam int DEN_W      = 25;
  localparam int IO_W       = 13;
  localparam int NUM_W      = 45;
  localparam int DIFF_W     = 38;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd3;

  // Opcodes of an input word.
  localparam logic OPC_ADD = 1'b0;
  localparam logic OPC_RUN = 1'b1;

  // Where a divider result goes.
  typedef enum logic [1:0] {
    DIV_START,
    DIV_BASE,
    DIV_TERM
  } div_src_e;

  typedef struct packed {
    logic              accept_add;
    logic              add_wr;
    logic              adj_re;
    logic              deg_re;
    logic              prev_re;
    logic              den_re;
    logic              next_re;
    logic              rd_b;
    logic [NODE_W-1:0] ia;
    logic [NODE_W-1:0] ib;
    logic              row_lat;
    logic              dg_clr;
    logic              dg_acc;
    logic              deg_wr;
    logic              sm_clr;
    logic              sm_acc;
    logic              den_mul;
    logic              den_wr;
    logic              div_go;
    div_src_e          div_src;
    logic              init_wr;
    logic              run_begin;
    logic              mn_io;
    logic              mn_mul;
    logic              dmp_mul;
    logic              next_wr;
    logic              pass_begin;
    logic              cp_wr;
    logic              pass_inc;
    logic              out_ld;
    logic              out_last;
    logic              adj_clr;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] n_m1;
    logic              div_busy;
    logic              div_done;
    logic              term_ok;
    logic              run_go;
    logic              diff_zero;
    logic              out_free;
  } stat_t;

  // Out-degree in half units; a page without out-links counts as one half.
  function automatic logic [OUTH_W-1:0] out_half(input logic [DEG_W-1:0] deg);
    logic [OUTH_W-1:0] res;
    if (deg == '0) begin
      res = OUTH_W'(1);
    end else begin
      res = {deg, 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/wpr_div.sv @@
`default_nettype none

module wpr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [wpr_pkg::NUM_W-1:0]  dividend_i,
  input  logic [wpr_pkg::DEN_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [wpr_pkg::NUM_W-1:0]  quot_o
);
  import wpr_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(NUM_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

@@ hdl/wpr_dp.sv @@
`default_nettype none

module wpr_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wpr_pkg::cmd_t                   cmd_i,
  output wpr_pkg::stat_t                  stat_o,
  input  logic [wpr_pkg::NODE_W-1:0]      src_node_i,
  input  logic [wpr_pkg::NODE_W-1:0]      dst_node_i,
  input  logic                            cfg_we_i,
  input  logic [wpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wpr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [wpr_pkg::NODE_W-1:0]      node_index_o,
  output logic [wpr_pkg::RANK_W-1:0]      rank_o,
  output logic                            last_o
);
  import wpr_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0]  node_count_q;
  logic [DAMP_W-1:0] damping_q;
  logic [RANK_W-1:0] tolerance_q;
  logic [ITER_W-1:0] max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(64);
      damping_q    <= DAMP_W'(55705);
      tolerance_q  <= RANK_W'(10737);
      max_iter_q   <= ITER_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NODE_COUNT: node_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_DAMPING:    damping_q    <= cfg_wdata_i[DAMP_W-1:0];
        CFG_TOLERANCE:  tolerance_q  <= cfg_wdata_i[RANK_W-1:0];
        CFG_MAX_ITER:   max_iter_q   <= cfg_wdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_cl;

  always_comb begin
    if (node_count_q < CNT_W'(2)) begin
      n_cl = CNT_W'(2);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      n_cl = CNT_W'(MAX_NODES);
    end else begin
      n_cl = node_count_q;
    end
  end

  logic [NODE_W-1:0] raddr;
  logic [NODE_W-1:0] waddr;

  assign raddr = cmd_i.rd_b ? cmd_i.ib : cmd_i.ia;
  assign waddr = cmd_i.ia;

  // Edge store: one row of target bits per source page, with a valid bit per row.
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_q;
  logic [MAX_NODES-1:0] row_vld_q;
  logic                 adj_vld_q;
  logic [MAX_NODES-1:0] adj_row;
  logic [NODE_W-1:0]    edge_src_q;
  logic [NODE_W-1:0]    edge_dst_q;
  logic [NODE_W-1:0]    adj_raddr;
  logic                 adj_rd;
  logic                 add_we;
  logic [MAX_NODES-1:0] dst_bit;

  assign adj_raddr = cmd_i.accept_add ? src_node_i : raddr;
  assign adj_rd    = cmd_i.accept_add | cmd_i.adj_re;
  assign adj_row   = adj_vld_q ? adj_q : '0;
  assign add_we    = cmd_i.add_wr && (edge_src_q != edge_dst_q);
  assign dst_bit   = MAX_NODES'(1) << edge_dst_q;

  always_ff @(posedge clk_i) begin
    if (adj_rd) begin
      adj_q <= adj_mem[adj_raddr];
    end
    if (add_we) begin
      adj_mem[edge_src_q] <= adj_row | dst_bit;
    end
    if (cmd_i.accept_add) begin
      edge_src_q <= src_node_i;
      edge_dst_q <= dst_node_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      adj_vld_q <= 1'b0;
    end else begin
      if (adj_rd) begin
        adj_vld_q <= row_vld_q[adj_raddr];
      end
      if (cmd_i.adj_clr) begin
        row_vld_q <= '0;
      end else if (add_we) begin
        row_vld_q[edge_src_q] <= 1'b1;
      end
    end
  end

  logic [MAX_NODES-1:0] row_lat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_lat) begin
      row_lat_q <= adj_row;
    end
  end

  // Degree table, in-degree in the upper half.
  logic [2*DEG_W-1:0] deg_mem [MAX_NODES];
  logic [2*DEG_W-1:0] deg_q;
  logic [DEG_W-1:0]   in_cnt_q;
  logic [DEG_W-1:0]   out_cnt_q;
  logic [DEG_W-1:0]   deg_in;
  logic [OUTH_W-1:0]  deg_outh;

  assign deg_in   = deg_q[2*DEG_W-1:DEG_W];
  assign deg_outh = out_half(deg_q[DEG_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.deg_re) begin
      deg_q <= deg_mem[raddr];
    end
    if (cmd_i.deg_wr) begin
      deg_mem[waddr] <= {in_cnt_q, out_cnt_q};
    end
    if (cmd_i.dg_clr) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else if (cmd_i.dg_acc) begin
      in_cnt_q  <= in_cnt_q + DEG_W'(adj_row[cmd_i.ia]);
      out_cnt_q <= out_cnt_q + DEG_W'(row_lat_q[cmd_i.ib]);
    end
  end

  // Per-source denominators.
  logic [SIN_W-1:0]  sin_q;
  logic [SOUT_W-1:0] sout_q;
  logic [DEN_W-1:0]  den_p_q;
  logic [DEN_W-1:0]  den_mem [MAX_NODES];
  logic [DEN_W-1:0]  den_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sm_clr) begin
      sin_q  <= '0;
      sout_q <= '0;
    end else if (cmd_i.sm_acc && row_lat_q[cmd_i.ib]) begin
      sin_q  <= sin_q + SIN_W'(deg_in);
      sout_q <= sout_q + SOUT_W'(deg_outh);
    end
    if (cmd_i.den_mul) begin
      den_p_q <= DEN_W'(sin_q) * DEN_W'(sout_q);
    end
    if (cmd_i.den_wr) begin
      den_mem[waddr] <= den_p_q;
    end
    if (cmd_i.den_re) begin
      den_q <= den_mem[raddr];
    end
  end

  // Rank buffers.
  logic [RANK_W-1:0] prev_mem [MAX_NODES];
  logic [RANK_W-1:0] next_mem [MAX_NODES];
  logic [RANK_W-1:0] prev_q;
  logic [RANK_W-1:0] next_q;
  logic [RANK_W-1:0] start_q;
  logic [RANK_W-1:0] base_q;
  logic [RANK_W-1:0] new_rank;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prev_re) begin
      prev_q <= prev_mem[raddr];
    end
    if (cmd_i.next_re) begin
      next_q <= next_mem[raddr];
    end
    if (cmd_i.init_wr) begin
      prev_mem[waddr] <= start_q;
    end else if (cmd_i.cp_wr) begin
      prev_mem[waddr] <= next_q;
    end
    if (cmd_i.next_wr) begin
      next_mem[waddr] <= new_rank;
    end
  end

  // Shared divider for the start value, the base term and every edge term.
  logic [NUM_W-1:0] div_a;
  logic [DEN_W-1:0] div_b;
  logic [NUM_W-1:0] quot;
  logic             div_busy;
  logic             div_done;
  div_src_e         div_src_q;
  logic [DAMP_W:0]  one_minus_d;
  logic [NUM_W-1:0] prod_q;

  assign one_minus_d = ((DAMP_W + 1)'(1) << DAMP_W) - {1'b0, damping_q};

  always_comb begin
    case (cmd_i.div_src)
      DIV_START: begin
        div_a = NUM_W'(1) << FRAC_BITS;
        div_b = DEN_W'(n_cl);
      end
      DIV_BASE: begin
        div_a = NUM_W'(one_minus_d) << (FRAC_BITS - DAMP_W);
        div_b = DEN_W'(n_cl);
      end
      default: begin
        div_a = prod_q;
        div_b = den_q;
      end
    endcase
  end

  wpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      div_src_q <= cmd_i.div_src;
    end
  end

  // Term accumulation and damping.
  logic [IO_W-1:0]            inout_q;
  logic [DEG_W+OUTH_W-1:0]    io_full;
  logic [RANK_W-1:0]          acc_q;
  logic [NUM_W:0]             acc_sum;
  logic [RANK_W+DAMP_W-1:0]   dprod_q;
  logic [RANK_W:0]            new_sum;

  assign io_full  = deg_in * deg_outh;
  assign acc_sum  = (NUM_W + 1)'(acc_q) + (NUM_W + 1)'(quot);
  assign new_sum  = {1'b0, base_q} + {1'b0, dprod_q[RANK_W+DAMP_W-1:DAMP_W]};
  assign new_rank = new_sum[RANK_W] ? '1 : new_sum[RANK_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mn_io) begin
      inout_q <= IO_W'(io_full);
    end
    if (cmd_i.mn_mul) begin
      prod_q <= NUM_W'(prev_q) * NUM_W'(inout_q);
    end
    if (cmd_i.dmp_mul) begin
      dprod_q <= (RANK_W + DAMP_W)'(acc_q) * (RANK_W + DAMP_W)'(damping_q);
    end
    if (cmd_i.mn_io) begin
      acc_q <= '0;
    end else if (div_done) begin
      case (div_src_q)
        DIV_START: start_q <= quot[RANK_W-1:0];
        DIV_BASE:  base_q  <= quot[RANK_W-1:0];
        DIV_TERM:  acc_q   <= (|acc_sum[NUM_W:RANK_W]) ? '1 : acc_sum[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Convergence bookkeeping.
  logic [DIFF_W-1:0] diff_q;
  logic [ITER_W-1:0] pass_q;
  logic [RANK_W-1:0] absd;

  assign absd = (next_q >= prev_q) ? (next_q - prev_q) : (prev_q - next_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
      pass_q <= '0;
    end else begin
      if (cmd_i.run_begin) begin
        diff_q <= DIFF_W'(tolerance_q);
      end else if (cmd_i.pass_begin) begin
        diff_q <= '0;
      end else if (cmd_i.cp_wr) begin
        diff_q <= diff_q + DIFF_W'(absd);
      end
      if (cmd_i.run_begin) begin
        pass_q <= '0;
      end else if (cmd_i.pass_inc) begin
        pass_q <= pass_q + ITER_W'(1);
      end
    end
  end

  // Output register.
  logic              out_valid_q;
  logic [NODE_W-1:0] node_q;
  logic [RANK_W-1:0] rank_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      node_q <= cmd_i.ia;
      rank_q <= prev_q;
      last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_index_o = node_q;
  assign rank_o       = rank_q;
  assign last_o       = last_q;

  assign stat_o.n_m1      = NODE_W'(n_cl - CNT_W'(1));
  assign stat_o.div_busy  = div_busy;
  assign stat_o.div_done  = div_done;
  assign stat_o.term_ok   = adj_row[cmd_i.ia] && (den_q != '0);
  assign stat_o.run_go    = (pass_q < max_iter_q) && (diff_q >= DIFF_W'(tolerance_q));
  assign stat_o.diff_zero = (diff_q == '0);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten while stalled");
  a_add_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> $past(cmd_i.accept_add))
    else $error("edge write without a preceding edge read");

endmodule

`default_nettype wire

@@ hdl/wpr_ctrl.sv @@
`default_nettype none

module wpr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           opcode_i,
  input  wpr_pkg::stat_t stat_i,
  output wpr_pkg::cmd_t  cmd_o
);
  import wpr_pkg::*;

  localparam logic [5:0] ST_IDLE   = 6'd0;
  localparam logic [5:0] ST_ADD    = 6'd1;
  localparam logic [5:0] ST_DIVS   = 6'd2;
  localparam logic [5:0] ST_DIVSW  = 6'd3;
  localparam logic [5:0] ST_DIVB   = 6'd4;
  localparam logic [5:0] ST_DIVBW  = 6'd5;
  localparam logic [5:0] ST_INIT   = 6'd6;
  localparam logic [5:0] ST_DG_ROW = 6'd7;
  localparam logic [5:0] ST_DG_LAT = 6'd8;
  localparam logic [5:0] ST_DG_RD  = 6'd9;
  localparam logic [5:0] ST_DG_ACC = 6'd10;
  localparam logic [5:0] ST_DG_WR  = 6'd11;
  localparam logic [5:0] ST_SM_ROW = 6'd12;
  localparam logic [5:0] ST_SM_LAT = 6'd13;
  localparam logic [5:0] ST_SM_RD  = 6'd14;
  localparam logic [5:0] ST_SM_ACC = 6'd15;
  localparam logic [5:0] ST_SM_MUL = 6'd16;
  localparam logic [5:0] ST_SM_WR  = 6'd17;
  localparam logic [5:0] ST_PCHK   = 6'd18;
  localparam logic [5:0] ST_MN_DEG = 6'd19;
  localparam logic [5:0] ST_MN_IO  = 6'd20;
  localparam logic [5:0] ST_MN_RD  = 6'd21;
  localparam logic [5:0] ST_MN_CHK = 6'd22;
  localparam logic [5:0] ST_MN_MUL = 6'd23;
  localparam logic [5:0] ST_MN_DW  = 6'd24;
  localparam logic [5:0] ST_MN_DMP = 6'd25;
  localparam logic [5:0] ST_MN_WR  = 6'd26;
  localparam logic [5:0] ST_CP_RD  = 6'd27;
  localparam logic [5:0] ST_CP_WR  = 6'd28;
  localparam logic [5:0] ST_PEND   = 6'd29;
  localparam logic [5:0] ST_EM_RD  = 6'd30;
  localparam logic [5:0] ST_EM_LD  = 6'd31;
  localparam logic [5:0] ST_CLR    = 6'd32;

  logic [5:0]        state_q, state_d;
  logic [NODE_W-1:0] ca_q, ca_d;
  logic [NODE_W-1:0] cb_q, cb_d;
  logic              last_a;
  logic              last_b;

  assign last_a = (ca_q == stat_i.n_m1);
  assign last_b = (cb_q == stat_i.n_m1);

  always_comb begin
    cmd_o         = cmd_t'('0);
    cmd_o.ia      = ca_q;
    cmd_o.ib      = cb_q;
    cmd_o.div_src = DIV_TERM;
    state_d       = state_q;
    ca_d          = ca_q;
    cb_d          = cb_q;
    in_stall_o    = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OPC_ADD) begin
            cmd_o.accept_add = 1'b1;
            state_d          = ST_ADD;
          end else begin
            cmd_o.run_begin = 1'b1;
            ca_d            = '0;
            state_d         = ST_DIVS;
          end
        end
      end
      ST_ADD: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DIVS: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DIV_START;
        state_d       = ST_DIVSW;
      end
      ST_DIVSW: begin
        if (stat_i.div_done) begin
          state_d = ST_DIVB;
        end
      end
      ST_DIVB: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DIV_BASE;
        state_d       = ST_DIVBW;
      end
      ST_DIVBW: begin
        if (stat_i.div_done) begin
          ca_d    = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (last_a) begin
          ca_d    = '0;
          state_d = ST_DG_ROW;
        end else begin
          ca_d = ca_q + NODE_W'(1);
        end
      end
      ST_DG_ROW: begin
        cmd_o.adj_re = 1'b1;
        state_d      = ST_DG_LAT;
      end
      ST_DG_LAT: begin
        cmd_o.row_lat = 1'b1;
        cmd_o.dg_clr  = 1'b1;
        cb_d          = '0;
        state_d       = ST_DG_RD;
      end
      ST_DG_RD: begin
        cmd_o.adj_re = 1'b1;
        cmd_o.rd_b   = 1'b1;
        state_d      = ST_DG_ACC;
      end
      ST_DG_ACC: begin
        cmd_o.dg_acc = 1'b1;
        if (last_b) begin
          state_d = ST_DG_WR;
        end else begin
          cb_d    = cb_q + NODE_W'(1);
          state_d = ST_DG_RD;
        end
      end
      ST_DG_WR: begin
        cmd_o.deg_wr = 1'b1;
        if (last_a) begin
          ca_d    = '0;
          state_d = ST_SM_ROW;
        end else begin
          ca_d    = ca_q + NODE_W'(1);
          state_d = ST_DG_ROW;
        end
      end
      ST_SM_ROW: begin
        cmd_o.adj_re = 1'b1;
        state_d      = ST_SM_LAT;
      end
      ST_SM_LAT: begin
        cmd_o.row_lat = 1'b1;
        cmd_o.sm_clr  = 1'b1;
        cb_d          = '0;
        state_d       = ST_SM_RD;
      end
      ST_SM_RD: begin
        cmd_o.deg_re = 1'b1;
        cmd_o.rd_b   = 1'b1;
        state_d      = ST_SM_ACC;
      end
      ST_SM_ACC: begin
        cmd_o.sm_acc = 1'b1;
        if (last_b) begin
          state_d = ST_SM_MUL;
        end else begin
          cb_d    = cb_q + NODE_W'(1);
          state_d = ST_SM_RD;
        end
      end
      ST_SM_MUL: begin
        cmd_o.den_mul = 1'b1;
        state_d       = ST_SM_WR;
      end
      ST_SM_WR: begin
        cmd_o.den_wr = 1'b1;
        if (last_a) begin
          ca_d    = '0;
          state_d = ST_PCHK;
        end else begin
          ca_d    = ca_q + NODE_W'(1);
          state_d = ST_SM_ROW;
        end
      end
      ST_PCHK: begin
        ca_d = '0;
        if (stat_i.run_go) begin
          cmd_o.pass_begin = 1'b1;
          state_d          = ST_MN_DEG;
        end else begin
          state_d = ST_EM_RD;
        end
      end
      ST_MN_DEG: begin
        cmd_o.deg_re = 1'b1;
        state_d      = ST_MN_IO;
      end
      ST_MN_IO: begin
        cmd_o.mn_io = 1'b1;
        cb_d        = '0;
        state_d     = ST_MN_RD;
      end
      ST_MN_RD: begin
        cmd_o.adj_re  = 1'b1;
        cmd_o.prev_re = 1'b1;
        cmd_o.den_re  = 1'b1;
        cmd_o.rd_b    = 1'b1;
        state_d       = ST_MN_CHK;
      end
      ST_MN_CHK: begin
        if (stat_i.term_ok) begin
          cmd_o.mn_mul = 1'b1;
          state_d      = ST_MN_MUL;
        end else if (last_b) begin
          state_d = ST_MN_DMP;
        end else begin
          cb_d    = cb_q + NODE_W'(1);
          state_d = ST_MN_RD;
        end
      end
      ST_MN_MUL: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DIV_TERM;
        state_d       = ST_MN_DW;
      end
      ST_MN_DW: begin
        if (stat_i.div_done) begin
          if (last_b) begin
            state_d = ST_MN_DMP;
          end else begin
            cb_d    = cb_q + NODE_W'(1);
            state_d = ST_MN_RD;
          end
        end
      end
      ST_MN_DMP: begin
        cmd_o.dmp_mul = 1'b1;
        state_d       = ST_MN_WR;
      end
      ST_MN_WR: begin
        cmd_o.next_wr = 1'b1;
        if (last_a) begin
          ca_d    = '0;
          state_d = ST_CP_RD;
        end else begin
          ca_d    = ca_q + NODE_W'(1);
          state_d = ST_MN_DEG;
        end
      end
      ST_CP_RD: begin
        cmd_o.next_re = 1'b1;
        cmd_o.prev_re = 1'b1;
        state_d       = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd_o.cp_wr = 1'b1;
        if (last_a) begin
          cmd_o.pass_inc = 1'b1;
          state_d        = ST_PEND;
        end else begin
          ca_d    = ca_q + NODE_W'(1);
          state_d = ST_CP_RD;
        end
      end
      ST_PEND: begin
        ca_d    = '0;
        state_d = stat_i.diff_zero ? ST_EM_RD : ST_PCHK;
      end
      ST_EM_RD: begin
        cmd_o.prev_re = 1'b1;
        state_d       = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = last_a;
          if (last_a) begin
            state_d = ST_CLR;
          end else begin
            ca_d    = ca_q + NODE_W'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      ST_CLR: begin
        cmd_o.adj_clr = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ca_q    <= '0;
      cb_q    <= '0;
    end else begin
      state_q <= state_d;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
    end
  end

  a_wait_on_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MN_DW) |-> (stat_i.div_busy || stat_i.div_done))
    else $error("waiting on a term division that is not running");

endmodule

`default_nettype wire

@@ hdl/weighted_page_rank.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   opcode_i, src_node_i, dst_node_i
// out       output     out_valid_o / out_stall_i node_index_o, rank_o, last_o
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// For an edge word, the row of its source is read, then written back with
// the target bit set. A run word performs the start and base divisions,
// seeds the ranks and sets up the degrees and denominators. Each pass then
// sends every edge term through the shared one-bit-per-cycle divider.
// Finally the emit loop sends out the N ranks, and a last step clears the
// edge store. Reset clears the control state and the row valid bits of the
// edge store at once. A stall on the result side holds the emit loop; the
// input side is stalled whenever the controller is not idle.

module weighted_page_rank (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [wpr_pkg::NODE_W-1:0]      src_node_i,
  input  logic [wpr_pkg::NODE_W-1:0]      dst_node_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [wpr_pkg::NODE_W-1:0]      node_index_o,
  output logic [wpr_pkg::RANK_W-1:0]      rank_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic [wpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wpr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import wpr_pkg::*;

  // The controller sequences the phases: edge load, start and base division,
  // degree count, denominator build, the update passes and the emit loop.
  // The datapath holds the edge store, the degree, denominator and rank
  // memories, the divider and the output register.
  cmd_t  cmd;
  stat_t stat;

  wpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wpr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .src_node_i   (src_node_i),
    .dst_node_i   (dst_node_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .node_index_o (node_index_o),
    .rank_o       (rank_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
